/* sv/imuyaw_pkg.sv */
// Shared types and constants for the IMU yaw frame parser and unwrap unit.
package imuyaw_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned ANGLE_W    = 17;
  localparam int unsigned TURN_W     = 32;
  localparam int unsigned UNWRAP_W   = 49;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_DATA_W = 104;

  localparam logic [BYTE_W-1:0]  HEADER_BYTE = 8'h55;
  localparam logic [BYTE_W-1:0]  ANGLE_TYPE  = 8'h53;
  localparam logic [CNT_W-1:0]   POS_TYPE    = 4'd1;
  localparam logic [CNT_W-1:0]   POS_YAW_LO  = 4'd6;
  localparam logic [CNT_W-1:0]   POS_YAW_HI  = 4'd7;
  localparam logic [CNT_W-1:0]   POS_CSUM    = 4'd10;

  // +/-170 degrees in 180/32768 degree units, rounded outward.
  localparam logic signed [ANGLE_W-1:0] EDGE_POS = 17'sd30948;
  localparam logic signed [ANGLE_W-1:0] EDGE_NEG = -17'sd30948;
  localparam logic [15:0]               HALF_TURN = 16'd32768;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_CSUM = 2'd1,
    ST_TYPE = 2'd2
  } status_t;

endpackage

/* sv/imu_yaw_frame_parser_unwrap_unit.sv */
// An accepted byte that closes a frame shows its result after it passes the input
// register and then the result register. Throughput: one byte per cycle while no closing byte stalls.
// The input register holds a byte while the result register is full and not taken;
// bytes that close no frame always drain. Only the frame-closing byte yields a result.
// Reset (rst_n low, synchronous): hunt for header, clear sums, angle and turn count,
// drop any held byte and result.
module imu_yaw_frame_parser_unwrap_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [imuyaw_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] rx_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [imuyaw_pkg::OUT_DATA_W-1:0]    out_tdata,  // [16:0] wrapped_angle,
                                                           // [48:17] turn_total,
                                                           // [97:49] unwrapped_angle,
                                                           // [103:98] zero
  output logic [imuyaw_pkg::STATUS_W-1:0]      out_tuser   // [1:0] frame_status
);
  import imuyaw_pkg::*;

  // Input register
  logic                s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0]   s1_byte_r;

  // Parser state
  logic                in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]   sum_r, sum_nxt;
  logic [BYTE_W-1:0]   type_r, type_nxt;
  logic [BYTE_W-1:0]   yaw_lo_r, yaw_lo_nxt;
  logic [BYTE_W-1:0]   yaw_hi_r, yaw_hi_nxt;
  logic signed [ANGLE_W-1:0] angle_r, angle_nxt;
  logic [TURN_W-1:0]   turns_r, turns_nxt;

  // Result register
  logic                      out_valid_r, out_valid_nxt;
  status_t                   status_r, status_nxt;
  logic signed [ANGLE_W-1:0] wrapped_r, wrapped_nxt;
  logic [TURN_W-1:0]         turn_out_r, turn_out_nxt;
  logic [UNWRAP_W-1:0]       unwrap_r, unwrap_nxt;

  logic                      closing;
  logic                      out_free;
  logic                      s1_go;
  logic                      still_in_frame;
  logic [15:0]               raw_yaw;
  logic signed [ANGLE_W-1:0] cur_angle;
  logic [UNWRAP_W-1:0]       high_part;

  // A byte that closes a frame needs a free result register; all others pass.
  assign closing   = in_frame_r && (cnt_r == POS_CSUM);
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!closing || out_free);
  assign in_tready = !s1_valid_r || s1_go;

  assign s1_valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);

  // Raw yaw above a half turn goes negative; exactly a half turn stays +180 degrees.
  assign raw_yaw   = {yaw_hi_r, yaw_lo_r};
  assign cur_angle = (raw_yaw > HALF_TURN) ? $signed({1'b1, raw_yaw})
                                           : $signed({1'b0, raw_yaw});

  always_comb begin
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    type_nxt     = type_r;
    yaw_lo_nxt   = yaw_lo_r;
    yaw_hi_nxt   = yaw_hi_r;
    angle_nxt    = angle_r;
    turns_nxt    = turns_r;
    status_nxt   = status_r;
    still_in_frame = in_frame_r;

    if (s1_go) begin
      if (in_frame_r && !closing) begin
        // Capture the fields of interest and advance the running sum.
        if (cnt_r == POS_TYPE)   type_nxt   = s1_byte_r;
        if (cnt_r == POS_YAW_LO) yaw_lo_nxt = s1_byte_r;
        if (cnt_r == POS_YAW_HI) yaw_hi_nxt = s1_byte_r;
        sum_nxt = sum_r + s1_byte_r;
        cnt_nxt = cnt_r + 1'b1;
      end else if (closing) begin
        in_frame_nxt   = 1'b0;
        still_in_frame = 1'b0;
        cnt_nxt        = '0;
        sum_nxt        = '0;
        if (sum_r != s1_byte_r) begin
          status_nxt = ST_CSUM;
        end else if (type_r != ANGLE_TYPE) begin
          status_nxt = ST_TYPE;
        end else begin
          status_nxt = ST_OK;
          // Count a turn on a jump across the +/-170 degree seam.
          if (angle_r >= EDGE_POS && cur_angle <= EDGE_NEG) begin
            turns_nxt = turns_r + 1'b1;
          end else if (angle_r <= EDGE_NEG && cur_angle >= EDGE_POS) begin
            turns_nxt = turns_r - 1'b1;
          end
          angle_nxt = cur_angle;
        end
      end
      // The closing byte may itself open the next frame.
      if (!still_in_frame && s1_byte_r == HEADER_BYTE) begin
        in_frame_nxt = 1'b1;
        sum_nxt      = HEADER_BYTE;
        cnt_nxt      = POS_TYPE;
      end
    end
  end

  // Unwrapped = angle + turns * 65536: low 16 bits are the angle, the upper
  // part is the turn count plus the angle's sign extension.
  assign high_part = {{(UNWRAP_W-TURN_W-16){turns_nxt[TURN_W-1]}}, turns_nxt, 16'h0000}
                   + {{(UNWRAP_W-ANGLE_W){angle_nxt[ANGLE_W-1]}}, angle_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    wrapped_nxt   = wrapped_r;
    turn_out_nxt  = turn_out_r;
    unwrap_nxt    = unwrap_r;
    if (s1_go && closing) begin
      out_valid_nxt = 1'b1;
      wrapped_nxt   = angle_nxt;
      turn_out_nxt  = turns_nxt;
      unwrap_nxt    = high_part;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      in_frame_r  <= 1'b0;
      cnt_r       <= '0;
      sum_r       <= '0;
      type_r      <= '0;
      yaw_lo_r    <= '0;
      yaw_hi_r    <= '0;
      angle_r     <= '0;
      turns_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ST_OK;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      in_frame_r  <= in_frame_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      type_r      <= type_nxt;
      yaw_lo_r    <= yaw_lo_nxt;
      yaw_hi_r    <= yaw_hi_nxt;
      angle_r     <= angle_nxt;
      turns_r     <= turns_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
    wrapped_r  <= wrapped_nxt;
    turn_out_r <= turn_out_nxt;
    unwrap_r   <= unwrap_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {{(OUT_DATA_W-UNWRAP_W-TURN_W-ANGLE_W){1'b0}},
                       unwrap_r, turn_out_r, wrapped_r};

  // Hold the byte counter inside a frame and at zero while hunting.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= POS_CSUM) && (in_frame_r || cnt_r == '0))
    else $error("byte counter out of range");

  // A result appears only after a frame-closing byte moved through.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && closing))
    else $error("result without a closing byte");

  // Status code is never the unused value.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r == ST_OK || status_r == ST_CSUM || status_r == ST_TYPE))
    else $error("bad frame status");

  // Unwrapped angle agrees with the wrapped angle in its fractional turn.
  a_unwrap_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (unwrap_r[15:0] == wrapped_r[15:0]))
    else $error("unwrapped angle inconsistent");

endmodule
